// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the event queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/ceq_pkg.sv =====
// Types and constants for the coalescing event queue.
package ceq_pkg;
  localparam int unsigned KeyW = 64;
  localparam int unsigned RepW = 32;
  localparam int unsigned EntW = KeyW + 1 + RepW;
  localparam logic [RepW-1:0] RepMax = '1;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_MERGED   = 3'd0,
    ST_APPENDED = 3'd1,
    ST_REPLACED = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_POPPED   = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_CLEARED  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_VIC_RD,
    S_VIC_CHK,
    S_MERGE_WR,
    S_POP_RD,
    S_OUT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic    load_in;     // capture the input transaction
    logic    pos_init_scan;
    logic    pos_init_vic;
    logic    pos_step;    // scan: move older; victim: move newer
    logic    rd_pos;      // read slot at current position
    logic    rd_oldest;   // read slot at oldest index
    logic    wr_merge;    // write back read entry with repeat + 1, saturating at RepMax
    logic    wr_append;
    logic    wr_replace;
    logic    wr_drop;
    logic    do_pop;
    logic    do_clear;
    logic    set_res;
    status_e res_status;
    logic    res_entry;   // key, flag, repeat from read data
    logic    res_rep;     // repeat + 1 (saturating at RepMax) only
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_e cmd;
    logic empty;
    logic full;
    logic scan_left;   // more scan positions remain after this one
    logic vic_left;
    logic key_hit;
    logic flag_clear;  // read entry is uninteresting
    logic flag_in;
    logic out_taken;
  } sts_t;
endpackage

// ===== rtl/ceq_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
module ceq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/ceq_ctrl.sv =====
// Controller state machine for the coalescing event queue.
module ceq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ceq_pkg::sts_t  sts_i,
  output ceq_pkg::ctl_t  ctl_o
);
  ceq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ceq_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    ctl_o.res_status = ceq_pkg::ST_EMPTY;
    in_ready_o = 1'b0;
    case (state_q)
      ceq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d = ceq_pkg::S_DISPATCH;
        end
      end
      // Dispatch on the captured command.
      ceq_pkg::S_DISPATCH: begin
        case (sts_i.cmd)
          ceq_pkg::CMD_PUSH: begin
            if (sts_i.empty) begin
              ctl_o.wr_append = 1'b1;
              ctl_o.set_res = 1'b1;
              ctl_o.res_status = ceq_pkg::ST_APPENDED;
              state_d = ceq_pkg::S_OUT;
            end else begin
              ctl_o.pos_init_scan = 1'b1;
              state_d = ceq_pkg::S_SCAN_RD;
            end
          end
          ceq_pkg::CMD_POP: begin
            if (sts_i.empty) begin
              ctl_o.set_res = 1'b1;
              ctl_o.res_status = ceq_pkg::ST_EMPTY;
              state_d = ceq_pkg::S_OUT;
            end else begin
              ctl_o.rd_oldest = 1'b1;
              state_d = ceq_pkg::S_POP_RD;
            end
          end
          ceq_pkg::CMD_CLEAR: begin
            ctl_o.do_clear = 1'b1;
            ctl_o.set_res = 1'b1;
            ctl_o.res_status = ceq_pkg::ST_CLEARED;
            state_d = ceq_pkg::S_OUT;
          end
          default: begin
            ctl_o.set_res = 1'b1;
            ctl_o.res_status = ceq_pkg::ST_EMPTY;
            state_d = ceq_pkg::S_OUT;
          end
        endcase
      end
      // Scan: read newest-first.
      ceq_pkg::S_SCAN_RD: begin
        ctl_o.rd_pos = 1'b1;
        state_d = ceq_pkg::S_SCAN_CHK;
      end
      ceq_pkg::S_SCAN_CHK: begin
        if (sts_i.key_hit) begin
          state_d = ceq_pkg::S_MERGE_WR;
        end else if (sts_i.scan_left) begin
          ctl_o.pos_step = 1'b1;
          state_d = ceq_pkg::S_SCAN_RD;
        end else if (!sts_i.full) begin
          ctl_o.wr_append = 1'b1;
          ctl_o.set_res = 1'b1;
          ctl_o.res_status = ceq_pkg::ST_APPENDED;
          state_d = ceq_pkg::S_OUT;
        end else if (sts_i.flag_in) begin
          ctl_o.pos_init_vic = 1'b1;
          state_d = ceq_pkg::S_VIC_RD;
        end else begin
          ctl_o.wr_drop = 1'b1;
          ctl_o.set_res = 1'b1;
          ctl_o.res_status = ceq_pkg::ST_DROPPED;
          state_d = ceq_pkg::S_OUT;
        end
      end
      ceq_pkg::S_MERGE_WR: begin
        ctl_o.wr_merge = 1'b1;
        ctl_o.set_res = 1'b1;
        ctl_o.res_rep = 1'b1;
        ctl_o.res_status = ceq_pkg::ST_MERGED;
        state_d = ceq_pkg::S_OUT;
      end
      // Victim search: read oldest-first.
      ceq_pkg::S_VIC_RD: begin
        ctl_o.rd_pos = 1'b1;
        state_d = ceq_pkg::S_VIC_CHK;
      end
      ceq_pkg::S_VIC_CHK: begin
        if (sts_i.flag_clear) begin
          ctl_o.wr_replace = 1'b1;
          ctl_o.set_res = 1'b1;
          ctl_o.res_status = ceq_pkg::ST_REPLACED;
          state_d = ceq_pkg::S_OUT;
        end else if (sts_i.vic_left) begin
          ctl_o.pos_step = 1'b1;
          state_d = ceq_pkg::S_VIC_RD;
        end else begin
          ctl_o.wr_drop = 1'b1;
          ctl_o.set_res = 1'b1;
          ctl_o.res_status = ceq_pkg::ST_DROPPED;
          state_d = ceq_pkg::S_OUT;
        end
      end
      ceq_pkg::S_POP_RD: begin
        ctl_o.do_pop = 1'b1;
        ctl_o.set_res = 1'b1;
        ctl_o.res_entry = 1'b1;
        ctl_o.res_status = ceq_pkg::ST_POPPED;
        state_d = ceq_pkg::S_OUT;
      end
      ceq_pkg::S_OUT: begin
        if (sts_i.out_taken) state_d = ceq_pkg::S_IDLE;
      end
      default: state_d = ceq_pkg::S_IDLE;
    endcase
  end
endmodule

// ===== rtl/ceq_dp.sv =====
// Datapath of the coalescing event queue: pointers, slot RAM, result register.
module ceq_dp #(
  parameter int unsigned Depth = 512,
  parameter int unsigned Scan  = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [1:0]               cmd_i,
  input  logic [ceq_pkg::KeyW-1:0] key_i,
  input  logic                     flag_i,
  input  ceq_pkg::ctl_t            ctl_i,
  output ceq_pkg::sts_t            sts_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [2:0]               status_o,
  output logic [ceq_pkg::KeyW-1:0] key_o,
  output logic                     flag_o,
  output logic [ceq_pkg::RepW-1:0] rep_o,
  output logic [$clog2(Depth):0]   occ_o
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] DepthC = CW'(Depth);
  localparam logic [CW-1:0] ScanC  = CW'((Scan < Depth) ? Scan : Depth);

  logic [1:0]               cmd_q;
  logic [ceq_pkg::KeyW-1:0] key_q;
  logic                     flag_q;
  logic [AW-1:0]            oldest_q, oldest_d;
  logic [CW-1:0]            fill_q, fill_d;
  logic [CW-1:0]            pos_q, pos_d;   // logical position
  logic [CW-1:0]            cnt_q, cnt_d;   // positions visited
  logic [AW-1:0]            rd_slot_q;
  logic [ceq_pkg::EntW-1:0] rdata;
  logic [ceq_pkg::KeyW-1:0] r_key;
  logic                     r_flag;
  logic [ceq_pkg::RepW-1:0] r_rep, r_rep_inc;
  logic                     out_valid_q;
  // Scan walks older, victim search walks newer; track direction by phase.
  logic                     vic_phase_q;

  // Wrap a logical position onto a slot.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = {1'b0, base} + {1'b0, p};
    if (s >= {1'b0, DepthC}) s = s - {1'b0, DepthC};
    return s[AW-1:0];
  endfunction

  assign r_key  = rdata[ceq_pkg::EntW-1 -: ceq_pkg::KeyW];
  assign r_flag = rdata[ceq_pkg::RepW];
  assign r_rep  = rdata[ceq_pkg::RepW-1:0];
  assign r_rep_inc = (r_rep == ceq_pkg::RepMax) ? r_rep : r_rep + 1'b1;

  logic                     we, re;
  logic [AW-1:0]            waddr, raddr;
  logic [ceq_pkg::EntW-1:0] wdata;

  always_comb begin
    we = 1'b0;
    waddr = phys(oldest_q, fill_q);
    wdata = {key_q, flag_q, {ceq_pkg::RepW{1'b0}}};
    if (ctl_i.wr_append) we = 1'b1;
    if (ctl_i.wr_drop) begin
      we = 1'b1;
      waddr = oldest_q;
    end
    if (ctl_i.wr_replace) begin
      we = 1'b1;
      waddr = rd_slot_q;
    end
    if (ctl_i.wr_merge) begin
      we = 1'b1;
      waddr = rd_slot_q;
      wdata = {r_key, r_flag, r_rep_inc};
    end
    re = ctl_i.rd_pos | ctl_i.rd_oldest;
    raddr = ctl_i.rd_oldest ? oldest_q : phys(oldest_q, pos_q);
  end

  ceq_ram #(.Width(ceq_pkg::EntW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    oldest_d = oldest_q;
    fill_d = fill_q;
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (ctl_i.pos_init_scan) begin
      pos_d = fill_q - 1'b1;
      cnt_d = '0;
    end
    if (ctl_i.pos_init_vic) begin
      pos_d = '0;
      cnt_d = '0;
    end
    if (ctl_i.pos_step) begin
      pos_d = vic_phase_q ? pos_q + 1'b1 : pos_q - 1'b1;
      cnt_d = cnt_q + 1'b1;
    end
    if (ctl_i.wr_append) fill_d = fill_q + 1'b1;
    if (ctl_i.wr_drop) oldest_d = phys(oldest_q, CW'(1));
    if (ctl_i.do_pop) begin
      oldest_d = phys(oldest_q, CW'(1));
      fill_d = fill_q - 1'b1;
    end
    if (ctl_i.do_clear) begin
      oldest_d = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      fill_q <= '0;
      out_valid_q <= 1'b0;
      vic_phase_q <= 1'b0;
    end else begin
      oldest_q <= oldest_d;
      fill_q <= fill_d;
      if (ctl_i.pos_init_scan) vic_phase_q <= 1'b0;
      if (ctl_i.pos_init_vic) vic_phase_q <= 1'b1;
      if (ctl_i.set_res) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q <= cmd_i;
      key_q <= key_i;
      flag_q <= flag_i;
    end
    pos_q <= pos_d;
    cnt_q <= cnt_d;
    if (re) rd_slot_q <= raddr;
    if (ctl_i.set_res) begin
      status_o <= ctl_i.res_status;
      key_o <= ctl_i.res_entry ? r_key : '0;
      flag_o <= ctl_i.res_entry ? r_flag : 1'b0;
      rep_o <= ctl_i.res_entry ? r_rep : (ctl_i.res_rep ? r_rep_inc : '0);
      occ_o <= fill_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sts_o.cmd = ceq_pkg::cmd_e'(cmd_q);
  assign sts_o.empty = (fill_q == '0);
  assign sts_o.full = (fill_q == DepthC);
  assign sts_o.scan_left = (cnt_q + 1'b1 < ((fill_q < ScanC) ? fill_q : ScanC));
  assign sts_o.vic_left = (cnt_q + 1'b1 < fill_q);
  assign sts_o.key_hit = (r_key == key_q);
  assign sts_o.flag_clear = !r_flag;
  assign sts_o.flag_in = flag_q;
  assign sts_o.out_taken = out_valid_q & out_ready_i;
endmodule

// ===== rtl/coalescing_event_queue.sv =====
// Coalescing event queue top level: controller, datapath and checks.
//
// Usage: commands enter on the s_axis channel (tdata: command, event_key,
// event_interesting from bit 0 up). Every transaction gives exactly one result
// on m_axis (tdata: status, entry_key_out, entry_flag_out, repeat_out,
// occupancy from bit 0 up).
// Pop, clear and unknown commands need no scan. A push reads one slot at a time
// from the newest entry backward, up to min(fill, SCAN) entries, through the
// single read port of the slot RAM; when the queue is full and the event is
// interesting it then reads oldest-first for an uninteresting victim, again one
// slot at a time.
// One command is in flight at a time.
// The result sits in an output register until m_axis_tready takes it; a new
// command is accepted only after that. Reset empties the queue at once; the
// slot RAM needs no clearing pass since only occupied slots are read.
`include "assert_macros.svh"
module coalescing_event_queue #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned SCAN  = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // command[1:0], event_key[65:2], event_interesting[66], zero pad
  input  logic [71:0]             s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // status[2:0], entry_key_out[66:3], entry_flag_out[67], repeat_out[99:68],
  // occupancy[..:100], zero pad
  output logic [((100 + $clog2(DEPTH) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  localparam int unsigned OW = $clog2(DEPTH) + 1;
  localparam int unsigned TW = ((100 + OW + 7) / 8) * 8;

  ceq_pkg::ctl_t ctl;
  ceq_pkg::sts_t sts;
  logic [2:0]  status;
  logic [63:0] key_out;
  logic        flag_out;
  logic [31:0] rep_out;
  logic [OW-1:0] occ;

  ceq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ceq_dp #(.Depth(DEPTH), .Scan(SCAN)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (s_axis_tdata[1:0]),
    .key_i       (s_axis_tdata[65:2]),
    .flag_i      (s_axis_tdata[66]),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_o    (status),
    .key_o       (key_out),
    .flag_o      (flag_out),
    .rep_o       (rep_out),
    .occ_o       (occ)
  );

  assign m_axis_tdata = {{(TW - 100 - OW){1'b0}}, occ, rep_out, flag_out, key_out, status};

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready,
    "input accepted while result pending")
  `ASSERT_IMPL(a_occ_range, clk_i, rst_ni, m_axis_tvalid, occ <= OW'(DEPTH),
    "occupancy beyond depth")
  `ASSERT_NEXT(a_one_result, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !m_axis_tvalid,
    "result raised in cycle after accept")
endmodule
